// File: src/btp_pkg.sv
// Shared types, field layout and constants for the branch target predictor.
package btp_pkg;

  // Program size; addresses wrap by keeping the low ADDR_W bits, so this stays a power of two.
  localparam int PROGRAM_WORDS = 512;
  localparam int ADDR_W        = $clog2(PROGRAM_WORDS);
  localparam int OFFSET_W      = 9;
  localparam int KIND_W        = 2;
  localparam int CODE_W        = 32;

  localparam int ENTRIES_DEFAULT = 64;

  // Input beat layout in tdata, lowest bit first.
  localparam int ADDR_LSB   = 0;
  localparam int OFFSET_LSB = ADDR_LSB + ADDR_W;
  localparam int KIND_LSB   = OFFSET_LSB + OFFSET_W;
  localparam int CODE_LSB   = KIND_LSB + KIND_W;
  localparam int S_FIELDS_W = CODE_LSB + CODE_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((ADDR_W + 7) / 8) * 8;
  localparam int M_TUSER_W  = 2;

  localparam logic ACT_LOOKUP  = 1'b0;
  localparam logic ACT_RESOLVE = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    COND_ZERO    = 2'd0,
    COND_NONZERO = 2'd1,
    COND_NEG     = 2'd2,
    COND_POS     = 2'd3
  } cond_kind_t;

endpackage

// File: src/btp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module btp_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/branch_target_predictor.sv
// Branch target buffer top level: fully associative table with a one-bit prediction per entry.
// Flow: an accepted beat goes to S_SEARCH, where the tag compare walks the filled slots one per
// cycle, then to S_EXEC, which loads the result once the output register is free.
// One item at a time: the next beat is taken only after the result is loaded and the FSM is back
// in S_IDLE; a result still waiting on m_tready stalls the next item in S_EXEC.
// Reset (synchronous): empties the table, clears all valid bits and drops any pending result.
module branch_target_predictor #(
  parameter int ENTRIES = btp_pkg::ENTRIES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // branch_address, branch_offset, condition_kind, condition_value, zero fill
  input  logic [btp_pkg::S_TDATA_W-1:0] s_tdata,
  // action
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // next_pc, zero fill
  output logic [btp_pkg::M_TDATA_W-1:0] m_tdata,
  // predicted_taken, redirect
  output logic [btp_pkg::M_TUSER_W-1:0] m_tuser
);

  import btp_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_EXEC   = 3'b100
  } state_t;

  state_t              state;
  logic                act;
  logic [ADDR_W-1:0]   addr;
  logic [OFFSET_W-1:0] offset;
  cond_kind_t          kind;
  logic [CODE_W-1:0]   code;
  logic [CW-1:0]       scan;
  logic                cmp_vld;
  logic [IW-1:0]       cmp_idx;
  logic [CW-1:0]       used;
  logic [IW-1:0]       slot;
  logic                slot_ok;
  logic                alloc;
  logic                hit_valid;
  logic [ADDR_W-1:0]   hit_target;
  logic [ENTRIES-1:0]  valid;
  logic                out_valid;
  logic [ADDR_W-1:0]   out_pc;
  logic                out_pt;
  logic                out_redirect;

  logic [ADDR_W-1:0]   tag_rd;
  logic [ADDR_W-1:0]   tgt_rd;
  logic                hit;
  logic                miss;
  logic                go;
  logic                taken;
  logic [ADDR_W-1:0]   taken_pc;
  logic [ADDR_W-1:0]   fall_pc;
  logic                tag_we;
  logic                tgt_we;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_W - ADDR_W){1'b0}}, out_pc};
  assign m_tuser  = {out_redirect, out_pt};

  // The comparison uses the tag read for the previous scan address, because the RAM read is registered.
  assign hit  = (state == S_SEARCH) && cmp_vld && (tag_rd == addr);
  assign miss = (state == S_SEARCH) && !cmp_vld && (scan == used);
  assign go   = (state == S_EXEC) && (!out_valid || m_tready);

  always_comb begin
    case (kind)
      COND_ZERO:    taken = (code == '0);
      COND_NONZERO: taken = (code != '0);
      COND_NEG:     taken = code[CODE_W-1];
      COND_POS:     taken = (code != '0) && !code[CODE_W-1];
      default:      taken = 1'b0;
    endcase
  end

  // Sums wrap at the program size by keeping only the low address bits.
  assign taken_pc = addr + offset;
  assign fall_pc  = addr + ADDR_W'(1);

  assign tag_we = go && alloc;
  assign tgt_we = go && (act == ACT_RESOLVE) && taken && !hit_valid && slot_ok;

  btp_ram #(.WIDTH(ADDR_W), .DEPTH(ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (slot),
    .wdata (addr),
    .raddr (scan[IW-1:0]),
    .rdata (tag_rd)
  );

  btp_ram #(.WIDTH(ADDR_W), .DEPTH(ENTRIES)) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (slot),
    .wdata (taken_pc),
    .raddr (scan[IW-1:0]),
    .rdata (tgt_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      valid     <= '0;
      out_valid <= 1'b0;
      cmp_vld   <= 1'b0;
      scan      <= '0;
    end else begin
      if (go) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act     <= s_tuser;
            addr    <= s_tdata[ADDR_LSB +: ADDR_W];
            offset  <= s_tdata[OFFSET_LSB +: OFFSET_W];
            kind    <= cond_kind_t'(s_tdata[KIND_LSB +: KIND_W]);
            code    <= s_tdata[CODE_LSB +: CODE_W];
            scan    <= '0;
            cmp_vld <= 1'b0;
            state   <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (hit) begin
            slot       <= cmp_idx;
            slot_ok    <= 1'b1;
            alloc      <= 1'b0;
            hit_valid  <= valid[cmp_idx];
            hit_target <= tgt_rd;
            state      <= S_EXEC;
          end else if (miss) begin
            hit_valid <= 1'b0;
            if (used != CW'(ENTRIES)) begin
              slot               <= used[IW-1:0];
              slot_ok            <= 1'b1;
              alloc              <= 1'b1;
              valid[used[IW-1:0]] <= 1'b0;
              used               <= used + CW'(1);
            end else begin
              slot_ok <= 1'b0;
              alloc   <= 1'b0;
            end
            state <= S_EXEC;
          end else begin
            cmp_vld <= (scan != used);
            cmp_idx <= scan[IW-1:0];
            if (scan != used) begin
              scan <= scan + CW'(1);
            end
          end
        end
        S_EXEC: begin
          if (go) begin
            out_pt    <= hit_valid;
            if (act == ACT_LOOKUP) begin
              out_pc       <= hit_valid ? hit_target : fall_pc;
              out_redirect <= 1'b0;
            end else begin
              out_pc       <= taken ? taken_pc : fall_pc;
              out_redirect <= (taken != hit_valid);
              if (taken && !hit_valid && slot_ok) begin
                valid[slot] <= 1'b1;
              end else if (!taken && hit_valid) begin
                valid[slot] <= 1'b0;
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(ENTRIES))
    else $error("fill count exceeds table size");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
    (used != $past(used)) |-> (used == $past(used) + CW'(1)))
    else $error("fill count moved by more than one slot");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second beat taken while an item is in flight");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    hit |-> ({1'b0, cmp_idx} < {1'b0, used}))
    else $error("tag match outside the filled slots");

endmodule

// File: tb/tb_branch_target_predictor.sv
// Self-checking testbench for the branch target predictor: directed and random lookup/resolve traffic.
`timescale 1ns / 1ps

module tb_branch_target_predictor;
  import btp_pkg::*;

  localparam int TBL_ENTRIES = ENTRIES_DEFAULT;
  localparam int HOT_N       = 32;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] addr;
    logic [OFFSET_W-1:0] offset;
    cond_kind_t        kind;
    logic [CODE_W-1:0] code;
  } branch_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_pc;
    logic              taken;
    logic              redirect;
  } pc_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  // Shadow copy of the branch table.
  logic [ADDR_W-1:0] tbl_tag[TBL_ENTRIES];
  logic [ADDR_W-1:0] tbl_target[TBL_ENTRIES];
  logic              tbl_valid[TBL_ENTRIES];
  int                tbl_used = 0;

  pc_result_t        pending_results[$];
  logic [ADDR_W-1:0] hot_addrs[HOT_N];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int items_sent    = 0;
  int errors        = 0;
  int cycles        = 0;
  int n_lookup      = 0;
  int n_resolve     = 0;
  int n_redirect    = 0;
  int n_full_miss   = 0;

  branch_target_predictor #(.ENTRIES(TBL_ENTRIES)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic branch_item_t make_item(logic act, logic [ADDR_W-1:0] addr,
                                             logic [OFFSET_W-1:0] off, cond_kind_t kind,
                                             logic [CODE_W-1:0] code);
    branch_item_t it;
    it.action = act;
    it.addr   = addr;
    it.offset = off;
    it.kind   = kind;
    it.code   = code;
    return it;
  endfunction

  // Condition codes lean toward the values where the branch conditions flip.
  function automatic logic [CODE_W-1:0] random_code();
    case ($urandom_range(5))
      0: return '0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Computes the result of one item and updates the shadow table.
  function automatic pc_result_t predict_branch(branch_item_t it);
    pc_result_t        r;
    int                slot;
    logic              hit_valid;
    logic              taken;
    logic [ADDR_W-1:0] taken_pc;
    logic [ADDR_W-1:0] fall_pc;
    slot = -1;
    for (int i = 0; i < tbl_used; i++) begin
      if (slot < 0 && tbl_tag[i] == it.addr) slot = i;
    end
    if (slot < 0 && tbl_used < TBL_ENTRIES) begin
      slot = tbl_used;
      tbl_tag[slot] = it.addr;
      tbl_valid[slot] = 1'b0;
      tbl_used++;
    end
    if (slot < 0) n_full_miss++;
    hit_valid = (slot >= 0) && tbl_valid[slot];
    // Nine-bit sums wrap exactly modulo the program size.
    fall_pc  = it.addr + 1'b1;
    taken_pc = it.addr + it.offset;
    r.taken    = hit_valid;
    r.redirect = 1'b0;
    if (it.action == ACT_LOOKUP) begin
      n_lookup++;
      r.next_pc = hit_valid ? tbl_target[slot] : fall_pc;
    end else begin
      n_resolve++;
      case (it.kind)
        COND_ZERO:    taken = (it.code == '0);
        COND_NONZERO: taken = (it.code != '0);
        COND_NEG:     taken = it.code[CODE_W-1];
        default:      taken = (it.code != '0) && !it.code[CODE_W-1];
      endcase
      r.next_pc = taken ? taken_pc : fall_pc;
      if (taken && !hit_valid) begin
        r.redirect = 1'b1;
        if (slot >= 0) begin
          tbl_target[slot] = taken_pc;
          tbl_valid[slot] = 1'b1;
        end
      end else if (!taken && hit_valid) begin
        r.redirect = 1'b1;
        tbl_valid[slot] = 1'b0;
      end
    end
    if (r.redirect) n_redirect++;
    return r;
  endfunction

  // Sends one beat; returns at the edge where it was accepted, with tvalid still high.
  task automatic send_branch(input branch_item_t it);
    logic [S_TDATA_W-1:0] d;
    d = '0;
    d[ADDR_LSB +: ADDR_W]     = it.addr;
    d[OFFSET_LSB +: OFFSET_W] = it.offset;
    d[KIND_LSB +: KIND_W]     = it.kind;
    d[CODE_LSB +: CODE_W]     = it.code;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= it.action;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_branch(it));
    items_sent++;
  endtask

  // Extremes of address and offset, wrap in both directions, every condition kind and
  // every outcome of a resolve against a valid and a not-valid entry.
  task automatic test_edges();
    send_branch(make_item(ACT_LOOKUP,  9'd0,   9'd0,   COND_ZERO,    '0));
    send_branch(make_item(ACT_LOOKUP,  9'd511, 9'd0,   COND_ZERO,    '0));
    send_branch(make_item(ACT_RESOLVE, 9'd511, 9'd255, COND_ZERO,    '0));
    send_branch(make_item(ACT_LOOKUP,  9'd511, 9'd0,   COND_ZERO,    '0));
    send_branch(make_item(ACT_RESOLVE, 9'd511, 9'd255, COND_ZERO,    32'd1));
    // An offset of 9'h100 is -256 and 9'h1FF is -1.
    send_branch(make_item(ACT_RESOLVE, 9'd0,   9'h100, COND_NONZERO, 32'h8000_0000));
    send_branch(make_item(ACT_RESOLVE, 9'd0,   9'h100, COND_NONZERO, 32'h8000_0000));
    send_branch(make_item(ACT_RESOLVE, 9'd0,   9'h1FF, COND_NEG,     32'hFFFF_FFFF));
    send_branch(make_item(ACT_RESOLVE, 9'd0,   9'h1FF, COND_NEG,     32'h7FFF_FFFF));
    send_branch(make_item(ACT_RESOLVE, 9'd0,   9'd0,   COND_POS,     32'h7FFF_FFFF));
    send_branch(make_item(ACT_RESOLVE, 9'd0,   9'd0,   COND_POS,     '0));
    send_branch(make_item(ACT_RESOLVE, 9'd0,   9'd0,   COND_POS,     32'h8000_0000));
    send_branch(make_item(ACT_RESOLVE, 9'd100, 9'd7,   COND_ZERO,    32'd5));
    send_branch(make_item(ACT_RESOLVE, 9'd200, 9'd1,   COND_NEG,     32'h8000_0000));
    send_branch(make_item(ACT_LOOKUP,  9'd200, 9'h1FF, COND_POS,     32'hFFFF_FFFF));
    send_branch(make_item(ACT_RESOLVE, 9'd300, 9'd44,  COND_NONZERO, '0));
    send_branch(make_item(ACT_RESOLVE, 9'd300, 9'd44,  COND_ZERO,    32'h8000_0000));
    send_branch(make_item(ACT_RESOLVE, 9'd300, 9'd44,  COND_POS,     32'd1));
    send_branch(make_item(ACT_LOOKUP,  9'd300, 9'd0,   COND_ZERO,    '0));
  endtask

  // Mostly lookup/resolve pairs on a small set of hot addresses, so entries are hit
  // and flip; the rest are lone items and fresh addresses.
  task automatic test_random_traffic(input int n_items);
    int                start;
    int                pick;
    logic [ADDR_W-1:0] a;
    start = items_sent;
    while (items_sent - start < n_items) begin
      a = ($urandom_range(3) != 0) ? hot_addrs[$urandom_range(HOT_N-1)]
                                   : ADDR_W'($urandom_range(511));
      pick = $urandom_range(9);
      if (pick < 6) begin
        send_branch(make_item(ACT_LOOKUP, a, OFFSET_W'($urandom_range(511)),
                              cond_kind_t'($urandom_range(3)), random_code()));
        send_branch(make_item(ACT_RESOLVE, a, OFFSET_W'($urandom_range(511)),
                              cond_kind_t'($urandom_range(3)), random_code()));
      end else begin
        send_branch(make_item(pick < 8 ? ACT_RESOLVE : ACT_LOOKUP, a,
                              OFFSET_W'($urandom_range(511)),
                              cond_kind_t'($urandom_range(3)), random_code()));
      end
    end
  endtask

  // Fills the table if needed, then misses on an address that has no slot.
  task automatic test_table_full();
    logic [ADDR_W-1:0] a;
    logic              present;
    while (tbl_used < TBL_ENTRIES) begin
      send_branch(make_item(ACT_LOOKUP, ADDR_W'($urandom_range(511)), '0, COND_ZERO, '0));
    end
    do begin
      a = ADDR_W'($urandom_range(511));
      present = 1'b0;
      for (int i = 0; i < tbl_used; i++) begin
        if (tbl_tag[i] == a) present = 1'b1;
      end
    end while (present);
    send_branch(make_item(ACT_LOOKUP,  a, 9'd3,   COND_ZERO, '0));
    send_branch(make_item(ACT_RESOLVE, a, 9'd3,   COND_ZERO, '0));
    send_branch(make_item(ACT_LOOKUP,  a, 9'd3,   COND_ZERO, '0));
    send_branch(make_item(ACT_RESOLVE, a, 9'h1F0, COND_NEG,  32'd9));
    // The last slot filled must still be found.
    send_branch(make_item(ACT_LOOKUP, tbl_tag[TBL_ENTRIES-1], '0, COND_ZERO, '0));
    send_branch(make_item(ACT_RESOLVE, tbl_tag[TBL_ENTRIES-1], 9'd5, COND_NONZERO, 32'd2));
  endtask

  always @(posedge clk) begin : check_results
    pc_result_t want;
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no pending prediction: next_pc=%0d", m_tdata[ADDR_W-1:0]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[ADDR_W-1:0] !== want.next_pc) begin
          $error("next_pc mismatch: expected %0d, actual %0d", want.next_pc,
                 m_tdata[ADDR_W-1:0]);
          errors++;
        end
        if (m_tuser[0] !== want.taken) begin
          $error("predicted_taken mismatch: expected %0b, actual %0b", want.taken, m_tuser[0]);
          errors++;
        end
        if (m_tuser[1] !== want.redirect) begin
          $error("redirect mismatch: expected %0b, actual %0b", want.redirect, m_tuser[1]);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < TBL_ENTRIES; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < HOT_N; i++) hot_addrs[i] = ADDR_W'($urandom_range(511));
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct  = 23;
    sink_idle_pct = 62;
    test_edges();
    test_random_traffic(500);
    test_table_full();

    src_idle_pct  = 62;
    sink_idle_pct = 23;
    test_random_traffic(700);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(700);

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TBL_ENTRIES + 8) @(posedge clk);

    $display("Covered %0d beats: %0d lookups, %0d resolves, %0d redirects.",
             items_sent, n_lookup, n_resolve, n_redirect);
    $display("Table reached %0d slots; %0d beats missed with no slot left.",
             tbl_used, n_full_miss);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
